[src/bilinear_texture_sampler_unit_defines.svh]
// assertion macros for the bilinear texture sampler
// used by bilinear_texture_sampler_unit; expects clk_i and rst_ni in scope
`ifndef BILINEAR_TEXTURE_SAMPLER_UNIT_DEFINES_SVH
`define BILINEAR_TEXTURE_SAMPLER_UNIT_DEFINES_SVH

// same-cycle implication
`define BTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bts_pkg.sv]
// shared constants, codes and types of the bilinear texture sampler
// no dependencies
package bts_pkg;

  localparam int DEF_MAX_TEX_WIDTH   = 256;
  localparam int DEF_MAX_TEX_HEIGHT  = 256;
  localparam int DEF_COORD_FRAC_BITS = 16;

  localparam int COORD_W    = 17;
  localparam int TXC_W      = 8;
  localparam int CH_W       = 8;
  localparam int NCH        = 3;
  localparam int TEXEL_W    = NCH * CH_W;
  localparam int SIZE_W     = 9;
  localparam int SIZE_RESET = 256;
  localparam int RES_W      = 16;
  localparam int NBANK      = 4;
  localparam int CFG_IDX_W  = 1;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEX_WIDTH  = 1'b0,
    REG_TEX_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [TEXEL_W-1:0] texel_t;

endpackage

[src/bts_if.sv]
// transaction channels of the bilinear texture sampler
// depends on bts_pkg
interface bts_in_if;
  import bts_pkg::*;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [TXC_W-1:0]   texel_x;
  logic [TXC_W-1:0]   texel_y;
  logic [CH_W-1:0]    texel_blue;
  logic [CH_W-1:0]    texel_green;
  logic [CH_W-1:0]    texel_red;
  logic [COORD_W-1:0] coord_u;
  logic [COORD_W-1:0] coord_v;

  modport source (
    output valid, opcode, texel_x, texel_y, texel_blue, texel_green, texel_red,
           coord_u, coord_v,
    input  ready
  );
  modport sink (
    input  valid, opcode, texel_x, texel_y, texel_blue, texel_green, texel_red,
           coord_u, coord_v,
    output ready
  );
endinterface

interface bts_out_if;
  import bts_pkg::*;
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] red;
  logic [RES_W-1:0] green;
  logic [RES_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

[src/bts_coord.sv]
// coordinate stage: saturates u, v to one and scales them by the texture size minus one
// depends on bts_pkg
module bts_coord #(
  parameter int COORD_FRAC_BITS = bts_pkg::DEF_COORD_FRAC_BITS
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       valid_i,
  output logic                                       ready_o,
  input  logic                                       opcode_i,
  input  logic [bts_pkg::TXC_W-1:0]                  texel_x_i,
  input  logic [bts_pkg::TXC_W-1:0]                  texel_y_i,
  input  bts_pkg::texel_t                            texel_i,
  input  logic [bts_pkg::COORD_W-1:0]                coord_u_i,
  input  logic [bts_pkg::COORD_W-1:0]                coord_v_i,
  input  logic [bts_pkg::SIZE_W-1:0]                 tex_width_i,
  input  logic [bts_pkg::SIZE_W-1:0]                 tex_height_i,
  output logic                                       valid_o,
  input  logic                                       ready_i,
  output logic                                       opcode_o,
  output logic [bts_pkg::TXC_W-1:0]                  texel_x_o,
  output logic [bts_pkg::TXC_W-1:0]                  texel_y_o,
  output bts_pkg::texel_t                            texel_o,
  output logic [COORD_FRAC_BITS+bts_pkg::SIZE_W:0]   ux_o,
  output logic [COORD_FRAC_BITS+bts_pkg::SIZE_W:0]   vy_o
);
  import bts_pkg::*;

  localparam int F   = COORD_FRAC_BITS;
  localparam int SW  = F + 1;
  localparam int EW  = (SW > COORD_W) ? SW : COORD_W;
  localparam int UXW = SW + SIZE_W;
  localparam logic [EW-1:0] ONE = EW'(1) << F;

  function automatic logic [SW-1:0] sat(input logic [COORD_W-1:0] c);
    logic [EW-1:0] e;
    e = EW'(c);
    if (e > ONE) e = ONE;
    return e[SW-1:0];
  endfunction

  logic               valid_q;
  logic               opcode_q;
  logic [TXC_W-1:0]   texel_x_q;
  logic [TXC_W-1:0]   texel_y_q;
  texel_t             texel_q;
  logic [UXW-1:0]     ux_q;
  logic [UXW-1:0]     vy_q;
  logic [UXW-1:0]     ux_d;
  logic [UXW-1:0]     vy_d;
  logic [SIZE_W-1:0]  wm1;
  logic [SIZE_W-1:0]  hm1;

  assign ready_o = !valid_q || ready_i;
  assign wm1     = tex_width_i - SIZE_W'(1);
  assign hm1     = tex_height_i - SIZE_W'(1);
  assign ux_d    = UXW'(sat(coord_u_i)) * UXW'(wm1);
  assign vy_d    = UXW'(sat(coord_v_i)) * UXW'(hm1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      opcode_q  <= opcode_i;
      texel_x_q <= texel_x_i;
      texel_y_q <= texel_y_i;
      texel_q   <= texel_i;
      ux_q      <= ux_d;
      vy_q      <= vy_d;
    end
  end

  assign valid_o   = valid_q;
  assign opcode_o  = opcode_q;
  assign texel_x_o = texel_x_q;
  assign texel_y_o = texel_y_q;
  assign texel_o   = texel_q;
  assign ux_o      = ux_q;
  assign vy_o      = vy_q;

endmodule

[src/bts_texmem.sv]
// texel memory in four banks by column and row parity, one 2x2 footprint a cycle unless stalled
// depends on bts_pkg
module bts_texmem #(
  parameter int MAX_TEX_WIDTH   = bts_pkg::DEF_MAX_TEX_WIDTH,
  parameter int MAX_TEX_HEIGHT  = bts_pkg::DEF_MAX_TEX_HEIGHT,
  parameter int COORD_FRAC_BITS = bts_pkg::DEF_COORD_FRAC_BITS
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  output logic                                     ready_o,
  input  logic                                     opcode_i,
  input  logic [bts_pkg::TXC_W-1:0]                texel_x_i,
  input  logic [bts_pkg::TXC_W-1:0]                texel_y_i,
  input  bts_pkg::texel_t                          texel_i,
  input  logic [COORD_FRAC_BITS+bts_pkg::SIZE_W:0] ux_i,
  input  logic [COORD_FRAC_BITS+bts_pkg::SIZE_W:0] vy_i,
  output logic                                     valid_o,
  input  logic                                     ready_i,
  output bts_pkg::texel_t                          bank_o [bts_pkg::NBANK],
  output logic                                     x0p_o,
  output logic                                     x1p_o,
  output logic                                     y0p_o,
  output logic                                     y1p_o,
  output logic [COORD_FRAC_BITS-1:0]               fx_o,
  output logic [COORD_FRAC_BITS-1:0]               fy_o
);
  import bts_pkg::*;

  localparam int F          = COORD_FRAC_BITS;
  localparam int UXW        = F + 1 + SIZE_W;
  localparam int XW         = $clog2(MAX_TEX_WIDTH);
  localparam int YW         = $clog2(MAX_TEX_HEIGHT);
  localparam int BANK_W     = (MAX_TEX_WIDTH + 1) / 2;
  localparam int BANK_H     = (MAX_TEX_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = BANK_W * BANK_H;
  localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  function automatic logic [BAW-1:0] bank_addr(input logic [XW-1:0] col,
                                               input logic [YW-1:0] row);
    return BAW'((int'(row) >> 1) * BANK_W + (int'(col) >> 1));
  endfunction

  logic          valid_q;
  logic          accept;
  logic          rd_en;
  logic          wr_en;
  logic [F-1:0]  fx;
  logic [F-1:0]  fy;
  logic [XW-1:0] x0;
  logic [XW-1:0] x1;
  logic [YW-1:0] y0;
  logic [YW-1:0] y1;
  logic [XW-1:0] wx;
  logic [YW-1:0] wy;
  logic [BAW-1:0] waddr;
  logic          x0p_q;
  logic          x1p_q;
  logic          y0p_q;
  logic          y1p_q;
  logic [F-1:0]  fx_q;
  logic [F-1:0]  fy_q;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;
  assign rd_en   = accept && (opcode_i == OP_SAMPLE);
  assign wr_en   = accept && (opcode_i == OP_WRITE)
                   && (int'(texel_x_i) < MAX_TEX_WIDTH)
                   && (int'(texel_y_i) < MAX_TEX_HEIGHT);

  assign fx    = ux_i[F-1:0];
  assign fy    = vy_i[F-1:0];
  assign x0    = XW'(ux_i[UXW-1:F]);
  assign y0    = YW'(vy_i[UXW-1:F]);
  assign x1    = x0 + XW'(fx != '0);
  assign y1    = y0 + YW'(fy != '0);
  assign wx    = XW'(texel_x_i);
  assign wy    = YW'(texel_y_i);
  assign waddr = bank_addr(wx, wy);

  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    localparam logic PX = 1'(b % 2);
    localparam logic PY = 1'(b / 2);

    texel_t         bank_mem [BANK_DEPTH];
    texel_t         rd_q;
    logic [XW-1:0]  col;
    logic [YW-1:0]  row;
    logic [BAW-1:0] raddr;
    logic           hit;

    assign col   = (x0[0] == PX) ? x0 : x1;
    assign row   = (y0[0] == PY) ? y0 : y1;
    assign raddr = bank_addr(col, row);
    assign hit   = (texel_x_i[0] == PX) && (texel_y_i[0] == PY);

    always_ff @(posedge clk_i) begin
      if (wr_en && hit) begin
        bank_mem[waddr] <= texel_i;
      end
      if (rd_en) begin
        rd_q <= bank_mem[raddr];
      end
    end

    assign bank_o[b] = rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i && (opcode_i == OP_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      x0p_q <= x0[0];
      x1p_q <= x1[0];
      y0p_q <= y0[0];
      y1p_q <= y1[0];
      fx_q  <= fx;
      fy_q  <= fy;
    end
  end

  assign valid_o = valid_q;
  assign x0p_o   = x0p_q;
  assign x1p_o   = x1p_q;
  assign y0p_o   = y0p_q;
  assign y1p_o   = y1p_q;
  assign fx_o    = fx_q;
  assign fy_o    = fy_q;

endmodule

[src/bts_filter.sv]
// two-stage bilinear blend: horizontal lerp per row, then vertical lerp
// depends on bts_pkg
module bts_filter #(
  parameter int COORD_FRAC_BITS = bts_pkg::DEF_COORD_FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  bts_pkg::texel_t              bank_i [bts_pkg::NBANK],
  input  logic                         x0p_i,
  input  logic                         x1p_i,
  input  logic                         y0p_i,
  input  logic                         y1p_i,
  input  logic [COORD_FRAC_BITS-1:0]   fx_i,
  input  logic [COORD_FRAC_BITS-1:0]   fy_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [bts_pkg::RES_W-1:0]    red_o,
  output logic [bts_pkg::RES_W-1:0]    green_o,
  output logic [bts_pkg::RES_W-1:0]    blue_o
);
  import bts_pkg::*;

  localparam int F     = COORD_FRAC_BITS;
  localparam int WW    = F + 1;
  localparam int RW    = F + CH_W;
  localparam int AW    = 2 * F + CH_W;
  localparam int SHIFT = 2 * F - CH_W;
  localparam logic [WW-1:0] ONE = WW'(1) << F;

  function automatic logic [RW-1:0] hlerp(input logic [CH_W-1:0] a,
                                          input logic [CH_W-1:0] b,
                                          input logic [F-1:0] f);
    logic [WW-1:0] wf;
    wf = ONE - WW'(f);
    return RW'(a) * RW'(wf) + RW'(b) * RW'(f);
  endfunction

  function automatic logic [AW-1:0] vlerp(input logic [RW-1:0] a,
                                          input logic [RW-1:0] b,
                                          input logic [F-1:0] f);
    logic [WW-1:0] wf;
    wf = ONE - WW'(f);
    return AW'(a) * AW'(wf) + AW'(b) * AW'(f);
  endfunction

  texel_t           t00;
  texel_t           t10;
  texel_t           t01;
  texel_t           t11;
  logic             d_valid_q;
  logic             d_ready;
  logic             e_valid_q;
  logic             e_ready;
  logic [RW-1:0]    rowf_q [NCH];
  logic [RW-1:0]    rowc_q [NCH];
  logic [F-1:0]     fy_q;
  logic [RES_W-1:0] res_q [NCH];
  logic [AW-1:0]    acc [NCH];

  assign t00 = bank_i[{y0p_i, x0p_i}];
  assign t10 = bank_i[{y0p_i, x1p_i}];
  assign t01 = bank_i[{y1p_i, x0p_i}];
  assign t11 = bank_i[{y1p_i, x1p_i}];

  assign e_ready = !e_valid_q || ready_i;
  assign d_ready = !d_valid_q || e_ready;
  assign ready_o = d_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
    end else begin
      if (d_ready) begin
        d_valid_q <= valid_i;
      end
      if (e_ready) begin
        e_valid_q <= d_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && d_ready) begin
      for (int c = 0; c < NCH; c++) begin
        rowf_q[c] <= hlerp(t00[c*CH_W +: CH_W], t10[c*CH_W +: CH_W], fx_i);
        rowc_q[c] <= hlerp(t01[c*CH_W +: CH_W], t11[c*CH_W +: CH_W], fx_i);
      end
      fy_q <= fy_i;
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      acc[c] = vlerp(rowf_q[c], rowc_q[c], fy_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_valid_q && e_ready) begin
      for (int c = 0; c < NCH; c++) begin
        res_q[c] <= acc[c][SHIFT +: RES_W];
      end
    end
  end

  // stored order is blue, green, red
  assign valid_o = e_valid_q;
  assign red_o   = res_q[2];
  assign green_o = res_q[1];
  assign blue_o  = res_q[0];

endmodule

[src/bilinear_texture_sampler_unit.sv]
// Bilinear texture sampler. Takes one transaction per clock cycle, writes and
// samples alike, and keeps that rate as long as results are taken. A sample
// passes a register stage each for coordinate scaling, texel fetch,
// horizontal blend and vertical blend. The rate is set by the texel memory,
// split into four banks by column and row parity so the 2x2 footprint is
// read in the same cycle, one port per bank. A write occupies the first two
// stages and gives no result. Texel memory is not cleared at reset; texels
// must be written before they are sampled.
// depends on bts_pkg, bts_if, bts_coord, bts_texmem, bts_filter and the defines header
`include "bilinear_texture_sampler_unit_defines.svh"

module bilinear_texture_sampler_unit #(
  parameter int MAX_TEX_WIDTH   = bts_pkg::DEF_MAX_TEX_WIDTH,
  parameter int MAX_TEX_HEIGHT  = bts_pkg::DEF_MAX_TEX_HEIGHT,
  parameter int COORD_FRAC_BITS = bts_pkg::DEF_COORD_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bts_in_if.sink                        in_if,
  bts_out_if.source                     out_if,
  input  logic                          cfg_we_i,
  input  logic [bts_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bts_pkg::SIZE_W-1:0]    cfg_data_i
);
  import bts_pkg::*;

  localparam int F   = COORD_FRAC_BITS;
  localparam int UXW = F + 1 + SIZE_W;
  localparam logic [SIZE_W-1:0] W_RESET =
    SIZE_W'((SIZE_RESET > MAX_TEX_WIDTH) ? MAX_TEX_WIDTH : SIZE_RESET);
  localparam logic [SIZE_W-1:0] H_RESET =
    SIZE_W'((SIZE_RESET > MAX_TEX_HEIGHT) ? MAX_TEX_HEIGHT : SIZE_RESET);

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] value,
                                                   input int maxv);
    logic [SIZE_W-1:0] r;
    if (value == '0) begin
      r = SIZE_W'(1);
    end else if (int'(value) > maxv) begin
      r = SIZE_W'(maxv);
    end else begin
      r = value;
    end
    return r;
  endfunction

  logic [SIZE_W-1:0] tex_width_q;
  logic [SIZE_W-1:0] tex_width_d;
  logic [SIZE_W-1:0] tex_height_q;
  logic [SIZE_W-1:0] tex_height_d;

  always_comb begin
    tex_width_d  = tex_width_q;
    tex_height_d = tex_height_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_TEX_WIDTH:  tex_width_d  = clamp_size(cfg_data_i, MAX_TEX_WIDTH);
        REG_TEX_HEIGHT: tex_height_d = clamp_size(cfg_data_i, MAX_TEX_HEIGHT);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_width_q  <= W_RESET;
      tex_height_q <= H_RESET;
    end else begin
      tex_width_q  <= tex_width_d;
      tex_height_q <= tex_height_d;
    end
  end

  texel_t           texel_in;
  logic             b_valid;
  logic             b_ready;
  logic             b_opcode;
  logic [TXC_W-1:0] b_texel_x;
  logic [TXC_W-1:0] b_texel_y;
  texel_t           b_texel;
  logic [UXW-1:0]   b_ux;
  logic [UXW-1:0]   b_vy;
  logic             c_valid;
  logic             c_ready;
  texel_t           c_bank [NBANK];
  logic             c_x0p;
  logic             c_x1p;
  logic             c_y0p;
  logic             c_y1p;
  logic [F-1:0]     c_fx;
  logic [F-1:0]     c_fy;

  assign texel_in = {in_if.texel_red, in_if.texel_green, in_if.texel_blue};

  bts_coord #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_coord (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_if.valid),
    .ready_o      (in_if.ready),
    .opcode_i     (in_if.opcode),
    .texel_x_i    (in_if.texel_x),
    .texel_y_i    (in_if.texel_y),
    .texel_i      (texel_in),
    .coord_u_i    (in_if.coord_u),
    .coord_v_i    (in_if.coord_v),
    .tex_width_i  (tex_width_q),
    .tex_height_i (tex_height_q),
    .valid_o      (b_valid),
    .ready_i      (b_ready),
    .opcode_o     (b_opcode),
    .texel_x_o    (b_texel_x),
    .texel_y_o    (b_texel_y),
    .texel_o      (b_texel),
    .ux_o         (b_ux),
    .vy_o         (b_vy)
  );

  bts_texmem #(
    .MAX_TEX_WIDTH   (MAX_TEX_WIDTH),
    .MAX_TEX_HEIGHT  (MAX_TEX_HEIGHT),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_texmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (b_valid),
    .ready_o   (b_ready),
    .opcode_i  (b_opcode),
    .texel_x_i (b_texel_x),
    .texel_y_i (b_texel_y),
    .texel_i   (b_texel),
    .ux_i      (b_ux),
    .vy_i      (b_vy),
    .valid_o   (c_valid),
    .ready_i   (c_ready),
    .bank_o    (c_bank),
    .x0p_o     (c_x0p),
    .x1p_o     (c_x1p),
    .y0p_o     (c_y0p),
    .y1p_o     (c_y1p),
    .fx_o      (c_fx),
    .fy_o      (c_fy)
  );

  bts_filter #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_filter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_valid),
    .ready_o (c_ready),
    .bank_i  (c_bank),
    .x0p_i   (c_x0p),
    .x1p_i   (c_x1p),
    .y0p_i   (c_y0p),
    .y1p_i   (c_y1p),
    .fx_i    (c_fx),
    .fy_i    (c_fy),
    .valid_o (out_if.valid),
    .ready_i (out_if.ready),
    .red_o   (out_if.red),
    .green_o (out_if.green),
    .blue_o  (out_if.blue)
  );

  `BTS_ASSERT_NXT(a_width_zero_is_one, cfg_we_i && cfg_idx_i == REG_TEX_WIDTH && cfg_data_i == '0, tex_width_q == SIZE_W'(1), "zero width not read as one")
  `BTS_ASSERT_NXT(a_height_zero_is_one, cfg_we_i && cfg_idx_i == REG_TEX_HEIGHT && cfg_data_i == '0, tex_height_q == SIZE_W'(1), "zero height not read as one")
  `BTS_ASSERT_IMP(a_column_pair, c_valid, (c_x1p != c_x0p) == (c_fx != '0), "ceil column parity does not match weight")
  `BTS_ASSERT_IMP(a_stall_only_when_full, !in_if.ready, out_if.valid && !out_if.ready, "input stalled with room in the pipeline")

endmodule

[verif/bilinear_texture_sampler_unit_checker.sv]
// checker for the bilinear texture sampler: watches both channels and the register port,
// keeps its own texel memory and texture size, and compares every filtered pixel
// depends on bts_pkg and bts_if
`timescale 1ns / 100ps

module bilinear_texture_sampler_unit_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bts_in_if                             in_mon,
  bts_out_if                            out_mon,
  input  logic                          cfg_we_i,
  input  logic [bts_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bts_pkg::SIZE_W-1:0]    cfg_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  import bts_pkg::*;

  localparam int MEM_COLS = DEF_MAX_TEX_WIDTH;
  localparam int MEM_ROWS = DEF_MAX_TEX_HEIGHT;
  localparam int FRAC     = DEF_COORD_FRAC_BITS;

  typedef struct packed {
    logic [RES_W-1:0] red;
    logic [RES_W-1:0] green;
    logic [RES_W-1:0] blue;
  } rgb_t;

  texel_t      texel_mem [0:MEM_COLS*MEM_ROWS-1];
  int unsigned tex_cols;
  int unsigned tex_rows;
  rgb_t        expected_pixel_q[$];

  function automatic int unsigned effective_size(logic [SIZE_W-1:0] raw, int unsigned limit);
    if (raw == '0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  function automatic rgb_t bilinear_rgb(logic [COORD_W-1:0] u_in, logic [COORD_W-1:0] v_in);
    longint unsigned one;
    longint unsigned u, v, ux, vy, fx, fy;
    longint unsigned c00, c10, c01, c11, row_lo, row_hi, acc;
    int unsigned     x0, x1, y0, y1;
    texel_t          t00, t10, t01, t11;
    logic [RES_W-1:0] chan [NCH];
    rgb_t            pix;
    one = 64'd1 << FRAC;
    u = (u_in > one) ? one : u_in;
    v = (v_in > one) ? one : v_in;
    ux = u * (tex_cols - 1);
    vy = v * (tex_rows - 1);
    fx = ux & (one - 1);
    fy = vy & (one - 1);
    x0 = 32'(ux >> FRAC);
    y0 = 32'(vy >> FRAC);
    x1 = x0 + ((fx != 0) ? 1 : 0);
    y1 = y0 + ((fy != 0) ? 1 : 0);
    t00 = texel_mem[y0*MEM_COLS + x0];
    t10 = texel_mem[y0*MEM_COLS + x1];
    t01 = texel_mem[y1*MEM_COLS + x0];
    t11 = texel_mem[y1*MEM_COLS + x1];
    for (int ch = 0; ch < NCH; ch++) begin
      c00 = t00[CH_W*ch +: CH_W];
      c10 = t10[CH_W*ch +: CH_W];
      c01 = t01[CH_W*ch +: CH_W];
      c11 = t11[CH_W*ch +: CH_W];
      row_lo = c00 * (one - fx) + c10 * fx;
      row_hi = c01 * (one - fx) + c11 * fx;
      acc = row_lo * (one - fy) + row_hi * fy;
      chan[ch] = RES_W'(acc >> (2*FRAC - 8));
    end
    // stored order is blue, green, red
    pix.blue  = chan[0];
    pix.green = chan[1];
    pix.red   = chan[2];
    return pix;
  endfunction

  task automatic check_channel(input string name, input logic [RES_W-1:0] exp_val,
                               input logic [RES_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rgb_t exp_pix;
    if (!rst_ni) begin
      tex_cols     = SIZE_RESET;
      tex_rows     = SIZE_RESET;
      fail_count_o = 0;
      expected_pixel_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_TEX_WIDTH:  tex_cols = effective_size(cfg_data_i, MEM_COLS);
          REG_TEX_HEIGHT: tex_rows = effective_size(cfg_data_i, MEM_ROWS);
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.opcode == OP_WRITE)
          texel_mem[in_mon.texel_y*MEM_COLS + in_mon.texel_x] =
            {in_mon.texel_red, in_mon.texel_green, in_mon.texel_blue};
        else
          expected_pixel_q.insert(expected_pixel_q.size(),
                                  bilinear_rgb(in_mon.coord_u, in_mon.coord_v));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_pixel_q.size() == 0) begin
          $error("unexpected pixel transaction: red %0h green %0h blue %0h",
                 out_mon.red, out_mon.green, out_mon.blue);
          fail_count_o++;
        end else begin
          exp_pix = expected_pixel_q.pop_front();
          check_channel("red", exp_pix.red, out_mon.red);
          check_channel("green", exp_pix.green, out_mon.green);
          check_channel("blue", exp_pix.blue, out_mon.blue);
        end
      end
    end
    pending_o = expected_pixel_q.size();
  end

endmodule

[verif/bilinear_texture_sampler_unit_tb.sv]
// top of the bilinear texture sampler testbench: clock, reset, texel writes and samples
// under random idling and one long output hold-off; the verdict comes from the checker
// depends on bts_pkg, bts_if, bilinear_texture_sampler_unit and its checker
`timescale 1ns / 100ps

module bilinear_texture_sampler_unit_tb;
  import bts_pkg::*;

  localparam int          CLK_PERIOD   = 10;
  localparam int          RESET_CYCLES = 8;
  localparam int          RANDOM_ITEMS = 750;
  localparam int          PRESS_ITEMS  = 60;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          SETTLE       = 8;
  localparam int          DRAIN        = 16;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int          MEM_COLS     = DEF_MAX_TEX_WIDTH;
  localparam int          MEM_ROWS     = DEF_MAX_TEX_HEIGHT;
  localparam logic [COORD_W-1:0] COORD_ONE = 17'h10000;
  localparam logic [COORD_W-1:0] COORD_MAX = 17'h1FFFF;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [SIZE_W-1:0]    cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned sent_count;
  int unsigned tex_cols;
  int unsigned tex_rows;
  bit          written_map [0:MEM_COLS*MEM_ROWS-1];
  logic        gaps_on;
  logic        hold_req;
  logic        hold_done;
  int unsigned hold_left;

  bts_in_if  in_ch ();
  bts_out_if out_ch ();

  bilinear_texture_sampler_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  bilinear_texture_sampler_unit_checker u_pixel_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #(CLK_PERIOD/2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("bilinear_texture_sampler_unit_tb: FAIL");
      $finish;
    end
  end

  // output side: random stalls, plus one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      out_ch.ready <= !(gaps_on && $urandom_range(99, 0) < 9);
    end
  end

  function automatic int unsigned texture_extent(logic [SIZE_W-1:0] raw, int unsigned limit);
    if (raw == '0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(15, 0))
      0:       return '0;
      1:       return COORD_ONE;
      2:       return COORD_W'($urandom_range(32'h1FFFF, 32'h10001));
      3:       return COORD_MAX;
      default: return COORD_W'($urandom_range(32'hFFFF, 0));
    endcase
  endfunction

  task automatic offer(input logic op, input logic [TXC_W-1:0] x, input logic [TXC_W-1:0] y,
                       input logic [CH_W-1:0] b, input logic [CH_W-1:0] g,
                       input logic [CH_W-1:0] r, input logic [COORD_W-1:0] u,
                       input logic [COORD_W-1:0] v);
    if (gaps_on && $urandom_range(99, 0) < 9) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.texel_x     <= x;
    in_ch.texel_y     <= y;
    in_ch.texel_blue  <= b;
    in_ch.texel_green <= g;
    in_ch.texel_red   <= r;
    in_ch.coord_u     <= u;
    in_ch.coord_v     <= v;
    @(negedge clk_i);
    while (!in_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
    sent_count++;
  endtask

  task automatic put_texel(input int unsigned x, input int unsigned y,
                           input logic [CH_W-1:0] b, input logic [CH_W-1:0] g,
                           input logic [CH_W-1:0] r);
    offer(OP_WRITE, TXC_W'(x), TXC_W'(y), b, g, r,
          COORD_W'($urandom_range(32'h1FFFF, 0)), COORD_W'($urandom_range(32'h1FFFF, 0)));
    written_map[y*MEM_COLS + x] = 1'b1;
  endtask

  task automatic take_sample(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
    offer(OP_SAMPLE, TXC_W'($urandom), TXC_W'($urandom), CH_W'($urandom), CH_W'($urandom),
          CH_W'($urandom), u, v);
  endtask

  task automatic set_texture_size(input logic [SIZE_W-1:0] w_raw,
                                  input logic [SIZE_W-1:0] h_raw);
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_TEX_WIDTH;
    cfg_data <= w_raw;
    @(posedge clk_i);
    cfg_idx  <= REG_TEX_HEIGHT;
    cfg_data <= h_raw;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    tex_cols = texture_extent(w_raw, MEM_COLS);
    tex_rows = texture_extent(h_raw, MEM_ROWS);
  endtask

  task automatic fill_texture();
    for (int y = 0; y < tex_rows; y++)
      for (int x = 0; x < tex_cols; x++)
        if (!written_map[y*MEM_COLS + x])
          put_texel(x, y, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
  endtask

  task automatic mixed_traffic(input int unsigned count);
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 55)
        take_sample(pick_coord(), pick_coord());
      else if (pick < 80)
        put_texel($urandom_range(tex_cols-1, 0), $urandom_range(tex_rows-1, 0),
                  CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
      else
        put_texel($urandom_range(MEM_COLS-1, 0), $urandom_range(MEM_ROWS-1, 0),
                  CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
    end
  endtask

  initial begin
    int unsigned      random_start;
    int unsigned      phase;
    logic [SIZE_W-1:0] w_raw;
    logic [SIZE_W-1:0] h_raw;

    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_WRITE;
    in_ch.texel_x     = '0;
    in_ch.texel_y     = '0;
    in_ch.texel_blue  = '0;
    in_ch.texel_green = '0;
    in_ch.texel_red   = '0;
    in_ch.coord_u     = '0;
    in_ch.coord_v     = '0;
    cfg_we            = 1'b0;
    cfg_idx           = REG_TEX_WIDTH;
    cfg_data          = '0;
    gaps_on           = 1'b1;
    hold_req          = 1'b0;
    sent_count        = 0;
    tex_cols          = SIZE_RESET;
    tex_rows          = SIZE_RESET;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full-size texture after reset: only the corners are touched
    put_texel(0, 0, 8'hFF, 8'hFF, 8'hFF);
    put_texel(MEM_COLS-1, 0, 8'h00, 8'h00, 8'h00);
    put_texel(0, MEM_ROWS-1, 8'h0F, 8'hF0, 8'h3C);
    put_texel(MEM_COLS-1, MEM_ROWS-1, 8'hA5, 8'h5A, 8'hC3);
    take_sample('0, '0);
    take_sample(COORD_ONE, '0);
    take_sample('0, COORD_ONE);
    take_sample(COORD_ONE, COORD_ONE);
    take_sample(COORD_MAX, COORD_MAX);
    take_sample(COORD_ONE + COORD_W'(1), '0);

    // size zero acts as a single texel
    set_texture_size('0, '0);
    take_sample(17'h1E240, 17'h0ABCD);
    take_sample(COORD_MAX, 17'h00001);
    take_sample(17'h08000, COORD_ONE);

    // 2x2 texture, blends and a sample straight after a write
    set_texture_size(9'd2, 9'd2);
    put_texel(1, 0, 8'h80, 8'h01, 8'hFE);
    put_texel(0, 1, 8'h7F, 8'hFF, 8'h00);
    put_texel(200, 100, 8'h55, 8'hAA, 8'h11);
    put_texel(1, 1, 8'h10, 8'h20, 8'h30);
    take_sample(17'h08000, 17'h08000);
    put_texel(1, 1, 8'hEE, 8'h77, 8'h99);
    take_sample(17'h08000, 17'h08000);
    take_sample(17'h04000, 17'h0C000);
    take_sample(17'h0FFFF, 17'h00001);
    take_sample(17'h00001, 17'h0FFFF);

    // output held off while the 2x2 texture keeps being sampled
    random_start = sent_count;
    hold_req <= 1'b1;
    repeat (PRESS_ITEMS) take_sample(pick_coord(), pick_coord());

    phase = 0;
    while (sent_count - random_start < RANDOM_ITEMS) begin
      case (phase)
        0: begin w_raw = 9'd511;  h_raw = 9'd1;   end
        1: begin w_raw = 9'd1;    h_raw = 9'd256; end
        default: begin
          case ($urandom_range(11, 0))
            0: begin
              w_raw = SIZE_W'($urandom_range(511, 256));
              h_raw = SIZE_W'($urandom_range(2, 0));
            end
            1: begin
              w_raw = SIZE_W'($urandom_range(1, 0));
              h_raw = SIZE_W'($urandom_range(511, 256));
            end
            2: begin
              w_raw = SIZE_W'($urandom_range(1, 0));
              h_raw = SIZE_W'($urandom_range(16, 0));
            end
            default: begin
              w_raw = SIZE_W'($urandom_range(16, 1));
              h_raw = SIZE_W'($urandom_range(16, 1));
            end
          endcase
        end
      endcase
      set_texture_size(w_raw, h_raw);
      // one phase runs with no idling on either side
      gaps_on <= (phase != 1);
      fill_texture();
      random_start += 0;
      mixed_traffic($urandom_range(90, 40));
      phase++;
    end

    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0)
      $display("bilinear_texture_sampler_unit_tb: PASS");
    else
      $display("bilinear_texture_sampler_unit_tb: FAIL");
    $finish;
  end

endmodule
